// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: transaction types, codes and sizes.
// No dependencies; every other file imports it.
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PRI_W     = 8;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [DATA_W-1:0]  item_data;
    logic        [PRI_W-1:0]   item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  popped_data;
    logic                      popped_valid;
    status_t                   status;
    logic        [COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic        [PRI_W-1:0]   prio;
    logic signed [DATA_W-1:0]  data;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and compares it with the new one.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     prev_entry,
  input  logic       prev_ge,
  input  entry_t     next_entry,
  input  logic       occupied,
  output entry_t     entry,
  output logic       ge
);

  entry_t entry_next;

  assign ge = occupied && (entry.prio > new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert && !ge) begin
      entry_next = prev_ge ? new_entry : prev_entry;
    end else if (ctrl.remove) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: a row of DEPTH cells shifting right on insert, left on remove.
// Result registered in the cycle after acceptance; one request per cycle while the
// result register is drained, throughput set by the single cell row update.
// Synchronous reset empties the queue (count to zero) and clears the result valid flag;
// slot contents are not reset. Depends on spq_pkg and spq_cell.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic                   accept;
  logic                   full;
  logic                   empty;
  cell_ctrl_t             ctrl;
  entry_t                 new_entry;
  entry_t                 cells [DEPTH];
  logic [DEPTH-1:0]       ge;
  out_item_t              result;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign new_entry = '{prio: in_item.item_priority, data: in_item.item_data};

  always_comb begin
    ctrl.insert = accept && (in_item.opcode == OP_INSERT) && !full;
    ctrl.remove = accept && (in_item.opcode == OP_REMOVE) && !empty;
    count_next  = count;
    if (ctrl.insert) count_next = count + CNT_W'(1);
    if (ctrl.remove) count_next = count - CNT_W'(1);
    count_ext = {{COUNT_W{1'b0}}, count_next};

    result.popped_data  = '0;
    result.popped_valid = 1'b0;
    result.status       = ST_OK;
    result.entry_count  = count_ext[COUNT_W-1:0];
    if (in_item.opcode == OP_INSERT) begin
      if (full) result.status = ST_OVERFLOW;
    end else begin
      if (empty) begin
        result.status = ST_UNDERFLOW;
      end else begin
        result.popped_data  = cells[0].data;
        result.popped_valid = 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_g;
    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_g = 1'b1;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_g = ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = cells[i];
    end else begin : g_mid
      assign next_e = cells[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_ge    (prev_g),
      .next_entry (next_e),
      .occupied   (count > CNT_W'(i)),
      .entry      (cells[i]),
      .ge         (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_item <= result;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.opcode == OP_INSERT && full
    |=> out_item.status == ST_OVERFLOW && $stable(count))
    else $error("insert into full queue not flagged");

  a_pop: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.opcode == OP_REMOVE && !empty
    |=> out_item.popped_valid && count == $past(count) - CNT_W'(1))
    else $error("remove did not pop head");

  for (genvar j = 1; j < DEPTH; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      ge[j] |-> ge[j-1])
      else $error("cell row out of priority order");
  end

endmodule

// ===== test/spq_checker.sv =====
// Checker for the sorted priority queue: watches both channels, keeps its own sorted
// copy of the queue, predicts each result transaction and compares it field by field.
// Depends on spq_pkg.
module spq_checker import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int QDEPTH = DEPTH_DEF;

  logic        [PRI_W-1:0]  slot_pri  [QDEPTH];
  logic signed [DATA_W-1:0] slot_data [QDEPTH];
  int                       held;
  out_item_t                awaited_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    held        = 0;
  end

  function automatic out_item_t predict_queue_result(in_item_t req);
    out_item_t res;
    int        pos;
    int        k;
    res        = '0;
    res.status = ST_OK;
    if (req.opcode == OP_INSERT) begin
      if (held >= QDEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held && slot_pri[pos] > req.item_priority) pos++;
        for (k = held; k > pos; k--) begin
          slot_pri[k]  = slot_pri[k-1];
          slot_data[k] = slot_data[k-1];
        end
        slot_pri[pos]  = req.item_priority;
        slot_data[pos] = req.item_data;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.popped_data  = slot_data[0];
        res.popped_valid = 1'b1;
        for (k = 1; k < held; k++) begin
          slot_pri[k-1]  = slot_pri[k];
          slot_data[k-1] = slot_data[k];
        end
        held--;
      end
    end
    res.entry_count = held[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      held = 0;
      awaited_results.delete();
    end else begin
      // retire the result first: it can only belong to an earlier request
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction: nothing outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.popped_data !== want.popped_data) begin
            $error("popped_data: expected %0d, got %0d", want.popped_data,
                   out_item.popped_data);
            mismatches++;
          end
          if (out_item.popped_valid !== want.popped_valid) begin
            $error("popped_valid: expected %0b, got %0b", want.popped_valid,
                   out_item.popped_valid);
            mismatches++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            mismatches++;
          end
          if (out_item.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_item.entry_count);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(predict_queue_result(in_item));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the sorted priority queue: clock, reset, request stimulus,
// random back-pressure, watchdog and verdict. Depends on spq_pkg,
// sorted_priority_queue and spq_checker.
module tb_top import spq_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned outstanding;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  spq_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  // hold the request until accepted; returns at the falling edge after the transaction
  task automatic send_request(opcode_t op, logic signed [DATA_W-1:0] data,
                              logic [PRI_W-1:0] pri);
    in_item_t req;
    req.opcode        = op;
    req.item_data     = data;
    req.item_priority = pri;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int                       ins_pct;
    logic signed [DATA_W-1:0] data;
    logic        [PRI_W-1:0]  pri;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty remove, ties at head and tail, fill, full insert, five removes
    send_request(OP_REMOVE, 32'sh1234_5678, 8'hff);
    send_request(OP_INSERT, 32'sh7fff_ffff, 8'd0);
    send_request(OP_INSERT, 32'sh8000_0000, 8'd255);
    send_request(OP_INSERT, -32'sd1, 8'd255);
    send_request(OP_INSERT, 32'sd0, 8'd0);
    for (int k = 1; k <= 12; k++) begin
      send_request(OP_INSERT, 32'(k * 32'h1111_1111), 8'(k * 20));
    end
    send_request(OP_INSERT, 32'sh5a5a_a5a5, 8'd128);
    repeat (5) send_request(OP_REMOVE, $urandom, 8'($urandom));

    // random: bursts leaning to insert, to remove or balanced, so the queue swings full and empty
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 24 == 0) begin
          case ($urandom_range(0, 2))
            0: ins_pct = 85;
            1: ins_pct = 15;
            default: ins_pct = 50;
          endcase
        end
        case ($urandom_range(0, 3))
          0: pri = 8'($urandom_range(0, 3));
          1: pri = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          default: pri = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
          0: data = 32'sh8000_0000;
          1: data = 32'sh7fff_ffff;
          2: data = -32'sd1;
          3: data = 32'sd0;
          default: data = $urandom;
        endcase
        if ($urandom_range(0, 99) < ins_pct) begin
          send_request(OP_INSERT, data, pri);
        end else begin
          send_request(OP_REMOVE, data, pri);
        end
      end
    end
    in_valid <= 1'b0;

    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
test/spq_checker.sv
test/tb_top.sv
